// ----- design/sprite_screen_projection_unit_defines.svh -----
// assertion macros for the sprite projection block
`ifndef SPRITE_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`define SPRITE_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SSPU_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("sspu check failed");
// next-cycle implication, checked out of reset
`define SSPU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("sspu check failed");
`else
`define SSPU_ASSERT(label, ante, cons)
`define SSPU_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- design/sspu_pkg.sv -----
// shared constants and types of the sprite projection block
package sspu_pkg;

    // screen defaults
    localparam int SCREEN_W_DEF = 640;
    localparam int SCREEN_H_DEF = 480;

    // fixed point and datapath widths
    localparam int Q_FRAC   = 16;
    localparam int WORD_W   = 32;
    localparam int NUM_W    = 66;
    localparam int DET_W    = 64;
    localparam int DQ_W     = 31;
    localparam int PQ_W     = 16;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic [WORD_W-1:0] RST_POS_X   = 32'h0000_0000;
    localparam logic [WORD_W-1:0] RST_POS_Y   = 32'h0000_0000;
    localparam logic [WORD_W-1:0] RST_DIR_X   = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] RST_DIR_Y   = 32'h0000_0000;
    localparam logic [WORD_W-1:0] RST_PLANE_X = 32'h0000_0000;
    localparam logic [WORD_W-1:0] RST_PLANE_Y = 32'h0000_A8F6;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_POS_X   = 3'd0,
        CFG_CAM_POS_Y   = 3'd1,
        CFG_CAM_DIR_X   = 3'd2,
        CFG_CAM_DIR_Y   = 3'd3,
        CFG_CAM_PLANE_X = 3'd4,
        CFG_CAM_PLANE_Y = 3'd5
    } t_cfg_idx;

endpackage

// ----- design/sspu_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module sspu_div #(
    parameter int NW = 82,
    parameter int DW = 64,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic [SW-1:0] o_side
);

    localparam int CW = (NW > DW) ? NW : DW;

    logic [DW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_low  [QW+1];
    logic [DW-1:0] r_den  [QW+1];
    logic          r_ovf  [QW+1];
    logic [SW-1:0] r_side [QW+1];
    logic [QW:0]   r_vld;
    logic [NW-1:0] w_hi;

    // entry stage: quotient range check and initial remainder
    assign w_hi = i_num >> QW;

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= DW'(w_hi);
        r_low[0]  <= i_num[QW-1:0];
        r_den[0]  <= i_den;
        r_ovf[0]  <= (CW'(w_hi) >= CW'(i_den));
        r_side[0] <= i_side;
    end

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    // one trial subtraction per stage
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0]   w_t;
        logic [DW:0]   w_sub;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_low;

        always_comb begin
            w_t   = {r_rem[k-1], r_low[k-1][QW-1]};
            w_sub = w_t - {1'b0, r_den[k-1]};
            w_ge  = (w_t >= {1'b0, r_den[k-1]});
            n_rem = w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
            n_low = {r_low[k-1][QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_low[k]  <= n_low;
            r_den[k]  <= r_den[k-1];
            r_ovf[k]  <= r_ovf[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_low[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_side  = r_side[QW];

endmodule

// ----- design/sprite_screen_projection_unit.sv -----
// top level of the sprite projection block
//
// Projects one sprite world position through the camera held in six
// configuration registers (position, direction, plane; Q16.16).
// Input: pulse start with the sprite position while busy is low; the
// item is taken at that clock edge. One item may be taken every cycle.
// Output: o_strobe marks one cycle in which the result fields are valid;
// results come out in input order and must be taken in that cycle, the
// receiver has no way to stall the block.
// Pipeline: two ranks of bit-per-stage dividers in series (32 stages for
// depth and lateral offset, 17 for column and size, entry stage included)
// plus ten multiply, sign and output stages.
// Throughput: one sprite per cycle while busy is low.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx at
// the clock edge; indexes past the last register are ignored. Write only
// while no sprite is in flight.
// Reset: synchronous, active low; the camera returns to its default, the
// pipeline is emptied and busy is high for the first cycle after reset.
`include "sprite_screen_projection_unit_defines.svh"
module sprite_screen_projection_unit #(
    parameter int SCREEN_W = sspu_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = sspu_pkg::SCREEN_H_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [sspu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sspu_pkg::WORD_W-1:0]     i_cfg_wdata,
    input  logic signed [31:0]              i_sprite_x,
    input  logic signed [31:0]              i_sprite_y,
    output logic                            o_strobe,
    output logic signed [15:0]              o_screen_col,
    output logic [15:0]                     o_sprite_size,
    output logic [14:0]                     o_start_col,
    output logic signed [15:0]              o_end_col,
    output logic [7:0]                      o_start_row,
    output logic [8:0]                      o_end_row,
    output logic signed [31:0]              o_depth,
    output logic                            o_in_front,
    output logic                            o_degenerate
);
    import sspu_pkg::*;

    localparam int HWW = $clog2(SCREEN_W / 2 + 1) + 1;
    localparam int CPW = 33 + HWW;
    localparam int SNW = $clog2(SCREEN_H + 1) + Q_FRAC;
    localparam int NW1 = NUM_W + Q_FRAC;
    localparam int LAT = 4 + (DQ_W + 1) + 4 + (PQ_W + 1) + 2;
    localparam logic signed [HWW-1:0] HALF_W   = HWW'(SCREEN_W / 2);
    localparam logic [SNW-1:0]        SIZE_NUM = SNW'(SCREEN_H * (2 ** Q_FRAC));
    localparam logic signed [17:0]    HH18     = 18'(SCREEN_H / 2);
    localparam logic signed [17:0]    H18      = 18'(SCREEN_H);
    localparam logic signed [17:0]    W18      = 18'(SCREEN_W);

    // configuration and control registers
    logic signed [31:0] r_cam_pos_x, r_cam_pos_y, r_cam_dir_x, r_cam_dir_y;
    logic signed [31:0] r_cam_plane_x, r_cam_plane_y;
    logic               r_busy;
    logic               w_accept;
    logic               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;

    // datapath registers
    logic signed [32:0]     r_dx, r_dy;
    logic signed [63:0]     r_p_pd, r_p_dp;
    logic signed [64:0]     r_p_ydx, r_p_xdy, r_p_pxdy, r_p_pydx;
    logic signed [64:0]     r_det;
    logic signed [65:0]     r_nx, r_ny;
    logic [DET_W-1:0]       r_det_mag;
    logic [NUM_W-1:0]       r_nx_mag, r_ny_mag;
    logic                   r_det_zero, r_nx_neg, r_ny_neg, r_det_neg;
    logic signed [31:0]     r_depth5, r_tx5, r_depth6, r_depth7, r_depth8;
    logic                   r_degen5, r_degen6, r_degen7, r_degen8;
    logic signed [32:0]     r_sum;
    logic [31:0]            r_dmag6, r_dmag7, r_dmag8;
    logic                   r_dneg6, r_dneg7, r_cneg8;
    logic signed [CPW-1:0]  r_cprod;
    logic [CPW-1:0]         r_cmag;
    logic signed [15:0]     r_col9;
    logic [15:0]            r_size9;
    logic signed [31:0]     r_depth9;
    logic                   r_degen9;
    logic signed [15:0]     r_out_col, r_out_ec;
    logic [15:0]            r_out_size;
    logic [14:0]            r_out_sc;
    logic [7:0]             r_out_sr;
    logic [8:0]             r_out_er;
    logic signed [31:0]     r_out_depth;
    logic                   r_out_front, r_out_degen;

    // divider hookups
    logic                   w_d1_vld;
    logic [DQ_W-1:0]        w_dq, w_tq;
    logic                   w_dovf, w_tovf;
    logic [1:0]             w_dside;
    logic                   w_tside;
    logic                   w_d2_vld;
    logic [PQ_W-1:0]        w_cq, w_sq;
    logic                   w_covf, w_sovf;
    logic [32:0]            w_cside;
    logic                   w_sside;

    // stage five and later combinational values
    logic [31:0]            w_dqx, w_tqx, n_depth5, n_tx5;
    logic                   w_csat;
    logic signed [15:0]     n_col9;
    logic [15:0]            w_cmagx;
    logic signed [17:0]     w_half, w_sr, w_er, w_sc, w_ec;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // configuration writes, busy and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_pos_x   <= RST_POS_X;
            r_cam_pos_y   <= RST_POS_Y;
            r_cam_dir_x   <= RST_DIR_X;
            r_cam_dir_y   <= RST_DIR_Y;
            r_cam_plane_x <= RST_PLANE_X;
            r_cam_plane_y <= RST_PLANE_Y;
            r_busy        <= 1'b1;
            {r_v1, r_v2, r_v3, r_v4} <= '0;
            {r_v5, r_v6, r_v7, r_v8, r_v9, r_v10} <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_CAM_POS_X:   r_cam_pos_x   <= i_cfg_wdata;
                    CFG_CAM_POS_Y:   r_cam_pos_y   <= i_cfg_wdata;
                    CFG_CAM_DIR_X:   r_cam_dir_x   <= i_cfg_wdata;
                    CFG_CAM_DIR_Y:   r_cam_dir_y   <= i_cfg_wdata;
                    CFG_CAM_PLANE_X: r_cam_plane_x <= i_cfg_wdata;
                    CFG_CAM_PLANE_Y: r_cam_plane_y <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_v1  <= w_accept;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= w_d1_vld;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= w_d2_vld;
            r_v10 <= r_v9;
        end
    end

    // offsets, products, differences, magnitudes
    always_ff @(posedge i_clk) begin
        r_dx       <= 33'(i_sprite_x) - 33'(r_cam_pos_x);
        r_dy       <= 33'(i_sprite_y) - 33'(r_cam_pos_y);
        r_p_pd     <= r_cam_plane_x * r_cam_dir_y;
        r_p_dp     <= r_cam_dir_x * r_cam_plane_y;
        r_p_ydx    <= r_cam_dir_y * r_dx;
        r_p_xdy    <= r_cam_dir_x * r_dy;
        r_p_pxdy   <= r_cam_plane_x * r_dy;
        r_p_pydx   <= r_cam_plane_y * r_dx;
        r_det      <= 65'(r_p_pd) - 65'(r_p_dp);
        r_nx       <= 66'(r_p_ydx) - 66'(r_p_xdy);
        r_ny       <= 66'(r_p_pxdy) - 66'(r_p_pydx);
        r_det_zero <= (r_det == '0);
        r_det_neg  <= r_det[64];
        r_det_mag  <= r_det[64] ? DET_W'(-r_det) : DET_W'(r_det);
        r_nx_neg   <= r_nx[65];
        r_nx_mag   <= r_nx[65] ? NUM_W'(-r_nx) : NUM_W'(r_nx);
        r_ny_neg   <= r_ny[65];
        r_ny_mag   <= r_ny[65] ? NUM_W'(-r_ny) : NUM_W'(r_ny);
    end

    // depth and lateral offset dividers
    sspu_div #(.NW(NW1), .DW(DET_W), .QW(DQ_W), .SW(2)) u_div_depth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_num   ({r_ny_mag, Q_FRAC'(0)}),
        .i_den   (r_det_mag),
        .i_side  ({r_ny_neg ^ r_det_neg, r_det_zero}),
        .o_valid (w_d1_vld),
        .o_quo   (w_dq),
        .o_ovf   (w_dovf),
        .o_side  (w_dside)
    );

    sspu_div #(.NW(NW1), .DW(DET_W), .QW(DQ_W), .SW(1)) u_div_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_num   ({r_nx_mag, Q_FRAC'(0)}),
        .i_den   (r_det_mag),
        .i_side  (r_nx_neg ^ r_det_neg),
        .o_valid (),
        .o_quo   (w_tq),
        .o_ovf   (w_tovf),
        .o_side  (w_tside)
    );

    // sign and saturation of the divider results
    always_comb begin
        w_dqx = {1'b0, w_dq};
        w_tqx = {1'b0, w_tq};
        if (w_dovf) begin
            n_depth5 = w_dside[1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            n_depth5 = w_dside[1] ? -w_dqx : w_dqx;
        end
        if (w_tovf) begin
            n_tx5 = w_tside ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            n_tx5 = w_tside ? -w_tqx : w_tqx;
        end
    end

    // column numerator and depth magnitude
    always_ff @(posedge i_clk) begin
        r_depth5 <= n_depth5;
        r_tx5    <= n_tx5;
        r_degen5 <= w_dside[0] || (n_depth5 == '0);
        r_sum    <= 33'(r_depth5) + 33'(r_tx5);
        r_depth6 <= r_depth5;
        r_dneg6  <= r_depth5[31];
        r_dmag6  <= r_depth5[31] ? 32'(-r_depth5) : 32'(r_depth5);
        r_degen6 <= r_degen5;
        r_cprod  <= r_sum * HALF_W;
        r_depth7 <= r_depth6;
        r_dneg7  <= r_dneg6 ^ r_sum[32];
        r_dmag7  <= r_dmag6;
        r_degen7 <= r_degen6;
        r_cmag   <= r_cprod[CPW-1] ? CPW'(-r_cprod) : CPW'(r_cprod);
        r_cneg8  <= r_dneg7;
        r_dmag8  <= r_dmag7;
        r_depth8 <= r_depth7;
        r_degen8 <= r_degen7;
    end

    // column and size dividers
    sspu_div #(.NW(CPW), .DW(32), .QW(PQ_W), .SW(33)) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v8),
        .i_num   (r_cmag),
        .i_den   (r_dmag8),
        .i_side  ({r_cneg8, r_depth8}),
        .o_valid (w_d2_vld),
        .o_quo   (w_cq),
        .o_ovf   (w_covf),
        .o_side  (w_cside)
    );

    sspu_div #(.NW(SNW), .DW(32), .QW(PQ_W), .SW(1)) u_div_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v8),
        .i_num   (SIZE_NUM),
        .i_den   (r_dmag8),
        .i_side  (r_degen8),
        .o_valid (),
        .o_quo   (w_sq),
        .o_ovf   (w_sovf),
        .o_side  (w_sside)
    );

    // column saturation
    always_comb begin
        w_csat  = w_covf || w_cq[15];
        w_cmagx = {1'b0, w_cq[14:0]};
        if (w_csat) begin
            n_col9 = w_cside[32] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            n_col9 = w_cside[32] ? -w_cmagx : w_cmagx;
        end
    end

    // draw rectangle
    always_comb begin
        w_half = $signed({3'b000, r_size9[15:1]});
        w_sr   = HH18 - w_half;
        w_er   = w_half + HH18;
        w_sc   = 18'(r_col9) - w_half;
        w_ec   = 18'(r_col9) + w_half;
        if (w_sr < 0) w_sr = '0;
        if (w_er >= H18) w_er = H18 - 18'sd1;
        if (w_sc < 0) w_sc = '0;
        if (w_ec >= W18) w_ec = W18 - 18'sd1;
    end

    // result registers
    always_ff @(posedge i_clk) begin
        r_col9   <= n_col9;
        r_size9  <= w_sovf ? 16'hFFFF : w_sq;
        r_depth9 <= w_cside[31:0];
        r_degen9 <= w_sside;
        if (r_degen9) begin
            r_out_col   <= '0;
            r_out_size  <= '0;
            r_out_sc    <= '0;
            r_out_ec    <= '0;
            r_out_sr    <= '0;
            r_out_er    <= '0;
            r_out_depth <= '0;
            r_out_front <= 1'b0;
        end else begin
            r_out_col   <= r_col9;
            r_out_size  <= r_size9;
            r_out_sc    <= w_sc[14:0];
            r_out_ec    <= w_ec[15:0];
            r_out_sr    <= w_sr[7:0];
            r_out_er    <= w_er[8:0];
            r_out_depth <= r_depth9;
            r_out_front <= !r_depth9[31] && (r_depth9 != '0);
        end
        r_out_degen <= r_degen9;
    end

    assign o_strobe      = r_v10;
    assign o_screen_col  = r_out_col;
    assign o_sprite_size = r_out_size;
    assign o_start_col   = r_out_sc;
    assign o_end_col     = r_out_ec;
    assign o_start_row   = r_out_sr;
    assign o_end_row     = r_out_er;
    assign o_depth       = r_out_depth;
    assign o_in_front    = r_out_front;
    assign o_degenerate  = r_out_degen;

    // checks
    `SSPU_ASSERT(a_strobe_lat, o_strobe, $past(w_accept, LAT))
    `SSPU_ASSERT(a_degen_zero, o_strobe && o_degenerate,
        o_depth == 0 && o_sprite_size == 0 && !o_in_front && o_screen_col == 0)
    `SSPU_ASSERT(a_front_sign, o_strobe && !o_degenerate, o_in_front == (o_depth > 0))
    `SSPU_ASSERT_NXT(a_busy_drop, r_busy, !r_busy)

endmodule
